// ===== hw/rtl/dcpe_pkg.sv =====
// Package with shared constants, types and the saturation helper for the evaluator.
`timescale 1ns / 1ps
package dcpe_pkg;
  localparam int MAX_DEGREE_DEF = 20;
  localparam logic [15:0] T_ONE = 16'd32768;
  localparam logic signed [15:0] VAL_ONE = 16'sd4096;
  localparam logic [4:0] DEGREE_RESET = 5'd3;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;
  localparam logic [1:0] ADDR_POLY_DEGREE = 2'd0;

  typedef struct packed {
    logic        load;
    logic        shift;
  } cell_ctrl_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage

// ===== hw/rtl/dcpe_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps
interface dcpe_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [4:0] point_index;
  logic signed [15:0] point_value;
  logic [15:0] param_t;
  modport source (output valid, func, point_index, point_value, param_t, input ready);
  modport sink (input valid, func, point_index, point_value, param_t, output ready);
endinterface

interface dcpe_out_if;
  logic valid;
  logic ready;
  logic [15:0] t_echo;
  logic signed [15:0] curve_value;
  modport source (output valid, t_echo, curve_value, input ready);
  modport sink (input valid, t_echo, curve_value, output ready);
endinterface

// ===== hw/rtl/dcpe_cell.sv =====
// One cell of the interpolation row: holds a value and interpolates toward its right neighbor.
`timescale 1ns / 1ps
module dcpe_cell (
  input  logic                clk,
  input  dcpe_pkg::cell_ctrl_t ctrl,
  input  logic signed [15:0]  load_value,
  input  logic signed [15:0]  right_value,
  input  logic [15:0]         t,
  output logic signed [15:0]  value
);
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [18:0] q;
  always_comb begin
    diff = 17'(right_value) - 17'(value);
    prod = $signed({18'd0, t}) * 34'(diff) + 34'sd16384;
    q = 19'(prod >>> 15);
  end
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= load_value;
    end else if (ctrl.shift) begin
      value <= dcpe_pkg::sat16(18'(value) + q[17:0]);
    end
  end
endmodule

// ===== hw/rtl/de_casteljau_polynomial_eval_core.sv =====
// Top level of the de Casteljau evaluator: control store, cell row and sequencer.
// A load is written to the control store when taken; an evaluate loads the row, runs D
// levels (D = clamped degree) and captures the result once the output is free.
// Throughput: loads back to back while idle; no new input until the result is captured.
// Reset (rst, synchronous): degree 3, every control value 1.0, no result pending.
`timescale 1ns / 1ps
module de_casteljau_polynomial_eval_core #(
  parameter int MAX_DEGREE = dcpe_pkg::MAX_DEGREE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  dcpe_in_if.sink      in_ch,
  dcpe_out_if.source   out_ch
);
  localparam int N = MAX_DEGREE + 1;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [4:0] poly_degree;
  logic signed [15:0] store [N];
  logic [N-1:0] written;
  logic [1:0] state;
  logic [4:0] count;
  logic [15:0] t;
  logic signed [15:0] cval [N];
  dcpe_pkg::cell_ctrl_t ctrl;
  logic [4:0] deg_eff;
  logic res_valid;
  logic [15:0] res_t;
  logic signed [15:0] res_value;
  logic res_load;

  assign pready = 1'b1;
  assign prdata = {27'd0, poly_degree};
  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.t_echo = res_t;
  assign out_ch.curve_value = res_value;
  assign res_load = (state == ST_OUT) && (!res_valid || out_ch.ready);

  always_comb begin
    if (poly_degree == 5'd0) deg_eff = 5'd1;
    else if (32'(poly_degree) > MAX_DEGREE) deg_eff = 5'(MAX_DEGREE);
    else deg_eff = poly_degree;
    ctrl.load = in_ch.valid && in_ch.ready && (in_ch.func == dcpe_pkg::FUNC_EVAL);
    ctrl.shift = (state == ST_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_degree <= dcpe_pkg::DEGREE_RESET;
      written <= '0;
      state <= ST_IDLE;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == dcpe_pkg::ADDR_POLY_DEGREE) begin
        poly_degree <= pwdata[4:0];
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            if (in_ch.func == dcpe_pkg::FUNC_EVAL) begin
              state <= ST_RUN;
              count <= deg_eff;
            end else if (32'(in_ch.point_index) < N) begin
              written[in_ch.point_index] <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          count <= count - 5'd1;
          if (count == 5'd1) state <= ST_OUT;
        end
        ST_OUT: begin
          if (res_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      if (in_ch.func == dcpe_pkg::FUNC_LOAD && 32'(in_ch.point_index) < N) begin
        store[in_ch.point_index] <= in_ch.point_value;
      end
      if (in_ch.func == dcpe_pkg::FUNC_EVAL) begin
        t <= (in_ch.param_t > dcpe_pkg::T_ONE) ? dcpe_pkg::T_ONE : in_ch.param_t;
      end
    end
    if (res_load) begin
      res_t <= t;
      res_value <= cval[0];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [15:0] right;
    logic signed [15:0] init;
    assign init = written[i] ? store[i] : dcpe_pkg::VAL_ONE;
    if (i == N - 1) begin : g_last
      assign right = cval[i];
    end else begin : g_mid
      assign right = cval[i+1];
    end
    dcpe_cell u_cell (
      .clk(clk), .ctrl(ctrl), .load_value(init), .right_value(right),
      .t(t), .value(cval[i])
    );
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.curve_value))
    else $error("result changed while stalled");
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> !in_ch.ready)
    else $error("input taken during evaluation");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> count != 5'd0)
    else $error("level counter underflow");
  a_eval_start: assert property (@(posedge clk) disable iff (rst)
    ctrl.load |=> state == ST_RUN)
    else $error("evaluation did not start");
endmodule
